@@ design/numeric_string_validator_core_defines.svh @@
// ----------------------------------------------------------------------------
// numeric string validator assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef NUMERIC_STRING_VALIDATOR_CORE_DEFINES_SVH
`define NUMERIC_STRING_VALIDATOR_CORE_DEFINES_SVH

// same-cycle implication
`define NSV_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("nsv assertion failed");

// next-cycle implication
`define NSV_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("nsv assertion failed");

`endif

@@ design/nsv_pkg.sv @@
// ----------------------------------------------------------------------------
// nsv_pkg
// shared types and character constants of the numeric string validator
// ----------------------------------------------------------------------------
`default_nettype none

package nsv_pkg;

    localparam int CHAR_W = 8;

    // ascii codes that steer the grammar
    localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
    localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CHAR_W-1:0] CH_EXP_UC = 8'h45;
    localparam logic [CHAR_W-1:0] CH_EXP_LC = 8'h65;

    // one input transaction
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              no_char;
        logic              last;
    } item_t;

    // character classes
    typedef struct packed {
        logic dig;
        logic sgn;
        logic pt;
        logic ex;
    } char_class_t;

endpackage

`default_nettype wire

@@ design/nsv_in_if.sv @@
// ----------------------------------------------------------------------------
// nsv_in_if
// character channel: valid/ready with at most one character per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface nsv_in_if;

    logic                      valid;
    logic                      ready;
    logic [nsv_pkg::CHAR_W-1:0] ch;
    logic                      no_char;
    logic                      last;

    modport source (output valid, output ch, output no_char, output last, input ready);
    modport sink   (input valid, input ch, input no_char, input last, output ready);

endinterface

`default_nettype wire

@@ design/nsv_out_if.sv @@
// ----------------------------------------------------------------------------
// nsv_out_if
// verdict channel: valid/ready with one verdict per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface nsv_out_if;

    logic valid;
    logic ready;
    logic is_num;

    modport source (output valid, output is_num, input ready);
    modport sink   (input valid, input is_num, output ready);

endinterface

`default_nettype wire

@@ design/nsv_char_class.sv @@
// ----------------------------------------------------------------------------
// nsv_char_class
// decodes one ascii byte into digit, sign, point and exponent-mark flags
// ----------------------------------------------------------------------------
`default_nettype none

module nsv_char_class
(
    input  wire logic [nsv_pkg::CHAR_W-1:0] ch,
    output nsv_pkg::char_class_t            cls
);
    import nsv_pkg::*;

    // byte compares, anything above 127 matches nothing
    always_comb
    begin
        cls.dig = (ch >= CH_ZERO) && (ch <= CH_NINE);
        cls.sgn = (ch == CH_PLUS) || (ch == CH_MINUS);
        cls.pt  = (ch == CH_POINT);
        cls.ex  = (ch == CH_EXP_UC) || (ch == CH_EXP_LC);
    end

endmodule

`default_nettype wire

@@ design/nsv_in_stage.sv @@
// ----------------------------------------------------------------------------
// nsv_in_stage
// input register: captures one character transaction per cycle while its slot is free
// ----------------------------------------------------------------------------
`default_nettype none

module nsv_in_stage
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    nsv_in_if.sink        chars,
    input  wire logic     adv,
    output logic          item_valid,
    output nsv_pkg::item_t item
);
    import nsv_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;

    // slot is free when empty or draining this cycle
    assign chars.ready = !valid_reg || adv;

    always_comb
    begin
        valid_next = valid_reg;
        if (chars.ready)
        begin
            valid_next = chars.valid;
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (chars.valid && chars.ready)
        begin
            item_reg.ch      <= chars.ch;
            item_reg.no_char <= chars.no_char;
            item_reg.last    <= chars.last;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

@@ design/nsv_phase_fsm.sv @@
// ----------------------------------------------------------------------------
// nsv_phase_fsm
// grammar phase register and verdict register with output handshake
// ----------------------------------------------------------------------------
`default_nettype none

`include "numeric_string_validator_core_defines.svh"

module nsv_phase_fsm
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           item_valid,
    input  nsv_pkg::item_t      item,
    input  nsv_pkg::char_class_t cls,
    output logic                adv,
    nsv_out_if.source           verdict
);
    import nsv_pkg::*;

    typedef enum logic [2:0] {
        PH_START,
        PH_SIGN,
        PH_INT,
        PH_FRAC,
        PH_EXP,
        PH_EXPD,
        PH_REJECT
    } phase_t;

    phase_t phase_reg;
    phase_t phase_next;
    phase_t phase_step;
    logic   res_valid_reg;
    logic   res_valid_next;
    logic   is_num_reg;
    logic   is_num_next;
    logic   accepts;

    // item moves on when the verdict slot is free or being taken
    assign adv = item_valid && (!res_valid_reg || verdict.ready);

    // grammar transition for one character
    always_comb
    begin
        case (phase_reg)
            PH_START:
            begin
                if (cls.sgn)
                    phase_step = PH_SIGN;
                else if (cls.dig)
                    phase_step = PH_INT;
                else if (cls.pt)
                    phase_step = PH_FRAC;
                else
                    phase_step = PH_REJECT;
            end
            PH_SIGN, PH_INT:
            begin
                if (cls.dig)
                    phase_step = PH_INT;
                else if (cls.pt)
                    phase_step = PH_FRAC;
                else
                    phase_step = PH_REJECT;
            end
            PH_FRAC:
            begin
                if (cls.dig)
                    phase_step = PH_FRAC;
                else if (cls.ex)
                    phase_step = PH_EXP;
                else
                    phase_step = PH_REJECT;
            end
            PH_EXP:
            begin
                if (cls.sgn || cls.dig)
                    phase_step = PH_EXPD;
                else
                    phase_step = PH_REJECT;
            end
            PH_EXPD:
            begin
                if (cls.dig)
                    phase_step = PH_EXPD;
                else
                    phase_step = PH_REJECT;
            end
            default:
            begin
                phase_step = PH_REJECT;
            end
        endcase
    end

    // phase after this transaction and verdict on string end
    always_comb
    begin
        phase_next     = phase_reg;
        res_valid_next = res_valid_reg && !verdict.ready;
        is_num_next    = is_num_reg;
        if (item.no_char)
            accepts = (phase_reg == PH_INT) || (phase_reg == PH_FRAC)
                   || (phase_reg == PH_EXP) || (phase_reg == PH_EXPD);
        else
            accepts = (phase_step == PH_INT) || (phase_step == PH_FRAC)
                   || (phase_step == PH_EXP) || (phase_step == PH_EXPD);
        if (adv)
        begin
            if (item.last)
            begin
                phase_next     = PH_START;
                res_valid_next = 1'b1;
                is_num_next    = accepts;
            end
            else if (!item.no_char)
            begin
                phase_next = phase_step;
            end
        end
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_START;
            res_valid_reg <= 1'b0;
            is_num_reg    <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            res_valid_reg <= res_valid_next;
            is_num_reg    <= is_num_next;
        end
    end

    assign verdict.valid  = res_valid_reg;
    assign verdict.is_num = is_num_reg;

    // checks
    `NSV_ASSERT_NEXT(a_end_restarts, adv && item.last, res_valid_reg && phase_reg == PH_START)
    `NSV_ASSERT_NEXT(a_empty_holds, adv && !item.last && item.no_char,
        phase_reg == $past(phase_reg))
    `NSV_ASSERT_NOW(a_no_overwrite, res_valid_reg && !verdict.ready, !adv)
    `NSV_ASSERT_NEXT(a_reject_sticks, adv && !item.last && phase_reg == PH_REJECT,
        phase_reg == PH_REJECT)

endmodule

`default_nettype wire

@@ design/numeric_string_validator_core.sv @@
// a verdict is registered in the verdict register once the transaction carrying last leaves the input register
// throughput: one character per cycle unless a stalled verdict register holds the flow
// a stalled verdict register holds the input register, which then stalls the source
// reset: rst_n asynchronous active low, clears valids and returns phase to start
// ----------------------------------------------------------------------------
// numeric_string_validator_core
// streams characters and reports whether each string is a decimal number
// ----------------------------------------------------------------------------
`default_nettype none

module numeric_string_validator_core
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    nsv_in_if.sink     chars,
    nsv_out_if.source  verdict
);
    import nsv_pkg::*;

    logic        adv;
    logic        item_valid;
    item_t       item;
    char_class_t cls;

    // input register
    nsv_in_stage u_in_stage
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .chars      (chars),
        .adv        (adv),
        .item_valid (item_valid),
        .item       (item)
    );

    // character decode
    nsv_char_class u_char_class
    (
        .ch  (item.ch),
        .cls (cls)
    );

    // phase and verdict
    nsv_phase_fsm u_phase_fsm
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .cls        (cls),
        .adv        (adv),
        .verdict    (verdict)
    );

endmodule

`default_nettype wire

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// numeric string validator testbench
// streams strings into the validator at most one character per transaction and
// checks each verdict against a grammar predictor or a fixed value: a directed
// table of boundary strings first, then random well-formed and broken strings
// under several idle and stall patterns, with one long back-pressure stretch
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import nsv_pkg::*;

    // grammar position after the characters read so far
    typedef enum logic [2:0] {
        GS_START,
        GS_SIGN,
        GS_INT,
        GS_FRAC,
        GS_EXP,
        GS_EXP_DIG,
        GS_REJECT
    } grammar_state_t;

    // how a directed row gets its expected verdict
    typedef enum logic {
        CHK_MODEL,
        CHK_FIXED
    } check_mode_t;

    typedef struct packed {
        item_t       it;
        check_mode_t mode;
        logic        verdict;
    } directed_row_t;

    localparam int NUM_DIRECTED = 25;
    localparam int HOLD_OFF_CYCLES = 200;
    localparam int MAX_GAP = 30;

    logic clk;
    logic rst_n;

    nsv_in_if  chars_if ();
    nsv_out_if verdict_if ();

    numeric_string_validator_core DUT
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .chars   (chars_if),
        .verdict (verdict_if)
    );

    grammar_state_t parse_state;
    logic           pending_verdicts [$];
    item_t          str_buf [$];
    int             errors;
    int             accepted_items;
    int             send_idle_pct;
    int             recv_stall_pct;
    int             hold_cycles;

    // directed strings: boundaries, several grammar branches, characterless items
    directed_row_t directed_rows [NUM_DIRECTED] = '{
        {8'hA5,     1'b1, 1'b1, CHK_FIXED, 1'b0},   // empty string
        {CH_PLUS,   1'b0, 1'b1, CHK_FIXED, 1'b0},   // lone plus
        {CH_MINUS,  1'b0, 1'b1, CHK_FIXED, 1'b0},   // lone minus
        {CH_POINT,  1'b0, 1'b1, CHK_FIXED, 1'b1},   // lone point
        {8'h31,     1'b0, 1'b0, CHK_MODEL, 1'b0},   // "1."
        {CH_POINT,  1'b0, 1'b1, CHK_FIXED, 1'b1},
        {CH_PLUS,   1'b0, 1'b0, CHK_MODEL, 1'b0},   // "+.5"
        {CH_POINT,  1'b0, 1'b0, CHK_MODEL, 1'b0},
        {8'h35,     1'b0, 1'b1, CHK_FIXED, 1'b1},
        {8'h31,     1'b0, 1'b0, CHK_MODEL, 1'b0},   // "1e5", exponent without point
        {CH_EXP_LC, 1'b0, 1'b0, CHK_MODEL, 1'b0},
        {8'h35,     1'b0, 1'b1, CHK_FIXED, 1'b0},
        {8'hFF,     1'b0, 1'b1, CHK_FIXED, 1'b0},   // top byte
        {8'h00,     1'b0, 1'b1, CHK_FIXED, 1'b0},   // bottom byte
        {CH_NINE,   1'b0, 1'b0, CHK_MODEL, 1'b0},   // "9" gap "."
        {8'h5A,     1'b1, 1'b0, CHK_MODEL, 1'b0},
        {CH_POINT,  1'b0, 1'b1, CHK_MODEL, 1'b0},
        {CH_POINT,  1'b0, 1'b0, CHK_MODEL, 1'b0},   // ".E-"
        {CH_EXP_UC, 1'b0, 1'b0, CHK_MODEL, 1'b0},
        {CH_MINUS,  1'b0, 1'b1, CHK_FIXED, 1'b1},
        {CH_MINUS,  1'b0, 1'b0, CHK_MODEL, 1'b0},   // "-" then end with no character
        {8'h3C,     1'b1, 1'b1, CHK_FIXED, 1'b0},
        {CH_ZERO,   1'b0, 1'b0, CHK_MODEL, 1'b0},   // "0.e"
        {CH_POINT,  1'b0, 1'b0, CHK_MODEL, 1'b0},
        {CH_EXP_LC, 1'b0, 1'b1, CHK_FIXED, 1'b1}
    };

    // grammar transition for one character
    function automatic grammar_state_t grammar_step(grammar_state_t st, logic [CHAR_W-1:0] c);
        logic dig;
        logic sgn;
        logic pt;
        logic ex;
        grammar_state_t nxt;
        dig = (c >= CH_ZERO) && (c <= CH_NINE);
        sgn = (c == CH_PLUS) || (c == CH_MINUS);
        pt  = (c == CH_POINT);
        ex  = (c == CH_EXP_UC) || (c == CH_EXP_LC);
        nxt = GS_REJECT;
        case (st)
            GS_START:
            begin
                if (sgn)
                    nxt = GS_SIGN;
                else if (dig)
                    nxt = GS_INT;
                else if (pt)
                    nxt = GS_FRAC;
            end
            GS_SIGN, GS_INT:
            begin
                if (dig)
                    nxt = GS_INT;
                else if (pt)
                    nxt = GS_FRAC;
            end
            GS_FRAC:
            begin
                if (dig)
                    nxt = GS_FRAC;
                else if (ex)
                    nxt = GS_EXP;
            end
            GS_EXP:
            begin
                if (sgn || dig)
                    nxt = GS_EXP_DIG;
            end
            GS_EXP_DIG:
            begin
                if (dig)
                    nxt = GS_EXP_DIG;
            end
            default:
            begin
                nxt = GS_REJECT;
            end
        endcase
        return nxt;
    endfunction

    // states in which the string read so far is a number
    function automatic logic state_is_number(grammar_state_t st);
        return (st == GS_INT) || (st == GS_FRAC) || (st == GS_EXP) || (st == GS_EXP_DIG);
    endfunction

    // geometric idle length for the given idle percentage
    function automatic int pick_gap(int pct);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < pct)
            gap++;
        return gap;
    endfunction

    function automatic logic [CHAR_W-1:0] pick_digit();
        return CH_ZERO + 8'($urandom_range(9));
    endfunction

    function automatic logic [CHAR_W-1:0] pick_sign();
        return ($urandom_range(1) != 0) ? CH_PLUS : CH_MINUS;
    endfunction

    // add one transaction at the tail of the string buffer
    task automatic append_item(item_t it);
        str_buf = {str_buf, it};
    endtask

    // add one expected verdict at the tail of the scoreboard
    task automatic expect_verdict(logic v);
        pending_verdicts = {pending_verdicts, v};
    endtask

    task automatic push_char(logic [CHAR_W-1:0] c);
        item_t it;
        it.ch      = c;
        it.no_char = 1'b0;
        it.last    = 1'b0;
        append_item(it);
    endtask

    task automatic push_digits(int max_len);
        int n;
        n = $urandom_range(max_len);
        repeat (n)
            push_char(pick_digit());
    endtask

    // one random string: mostly grammar-shaped, some noise, empty and corrupted
    task automatic build_random_string();
        int    kind;
        int    n;
        int    pos;
        item_t it;
        str_buf.delete();
        kind = $urandom_range(99);
        if (kind < 4)
        begin
            it.ch      = 8'($urandom);
            it.no_char = 1'b1;
            it.last    = 1'b1;
            append_item(it);
        end
        else
        begin
            if (kind < 12)
            begin
                n = $urandom_range(1, 5);
                repeat (n)
                    push_char(8'($urandom_range(255)));
            end
            else
            begin
                if ($urandom_range(2) == 0)
                    push_char(pick_sign());
                push_digits(3);
                if ($urandom_range(3) != 0)
                begin
                    push_char(CH_POINT);
                    push_digits(3);
                    if ($urandom_range(1) != 0)
                    begin
                        push_char(($urandom_range(1) != 0) ? CH_EXP_UC : CH_EXP_LC);
                        if ($urandom_range(1) != 0)
                            push_char(pick_sign());
                        push_digits(3);
                    end
                end
                else if ($urandom_range(5) == 0)
                begin
                    // exponent straight after the integer digits
                    push_char(($urandom_range(1) != 0) ? CH_EXP_UC : CH_EXP_LC);
                    push_digits(2);
                end
                if (str_buf.size() == 0)
                    push_char(pick_digit());
                // corrupt one character now and then
                if ($urandom_range(4) == 0)
                begin
                    pos = $urandom_range(str_buf.size() - 1);
                    it = str_buf[pos];
                    it.ch = 8'($urandom_range(255));
                    str_buf[pos] = it;
                end
            end
            // characterless filler inside the string
            if ($urandom_range(5) == 0)
            begin
                pos = $urandom_range(str_buf.size());
                it.ch      = 8'($urandom);
                it.no_char = 1'b1;
                it.last    = 1'b0;
                str_buf.insert(pos, it);
            end
            // end mark on the last character or on a characterless transaction
            if ($urandom_range(7) == 0)
            begin
                it.ch      = 8'($urandom);
                it.no_char = 1'b1;
                it.last    = 1'b1;
                append_item(it);
            end
            else
            begin
                it = str_buf[str_buf.size() - 1];
                it.last = 1'b1;
                str_buf[str_buf.size() - 1] = it;
            end
        end
    endtask

    // offer one transaction, wait for acceptance, then predict
    task automatic send_item(item_t it, check_mode_t mode, logic fixed_verdict);
        int gap;
        gap = pick_gap(send_idle_pct);
        @(negedge clk);
        if (gap > 0)
        begin
            chars_if.valid <= 1'b0;
            chars_if.ch    <= 8'($urandom);
            repeat (gap)
                @(negedge clk);
        end
        chars_if.valid   <= 1'b1;
        chars_if.ch      <= it.ch;
        chars_if.no_char <= it.no_char;
        chars_if.last    <= it.last;
        @(posedge clk);
        while (!(chars_if.valid && chars_if.ready))
            @(posedge clk);
        accepted_items++;
        if (!it.no_char)
            parse_state = grammar_step(parse_state, it.ch);
        if (it.last)
        begin
            if (mode == CHK_FIXED)
                expect_verdict(fixed_verdict);
            else
                expect_verdict(state_is_number(parse_state));
            parse_state = GS_START;
        end
    endtask

    task automatic stop_sending();
        @(negedge clk);
        chars_if.valid <= 1'b0;
    endtask

    // sender pause until every expected verdict has arrived
    task automatic drain_verdicts();
        while (pending_verdicts.size() != 0)
            @(posedge clk);
    endtask

    task automatic run_random_phase(int send_pct, int recv_pct, int count);
        int start_count;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start_count    = accepted_items;
        while (accepted_items - start_count < count)
        begin
            build_random_string();
            foreach (str_buf[i])
                send_item(str_buf[i], CHK_MODEL, 1'b0);
        end
        stop_sending();
        drain_verdicts();
    endtask

    // clock
    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // receiver ready: random stalls plus a long hold-off while hold_cycles counts down
    initial
    begin
        verdict_if.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                verdict_if.ready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                verdict_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // verdict checker
    always @(posedge clk)
    begin
        if (rst_n && verdict_if.valid && verdict_if.ready)
        begin
            if (pending_verdicts.size() == 0)
            begin
                $display("%0t: unexpected verdict, expected none, actual is_num=%0b",
                         $time, verdict_if.is_num);
                errors++;
            end
            else
            begin
                if (verdict_if.is_num !== pending_verdicts[0])
                begin
                    $display("%0t: is_num mismatch, expected %0b, actual %0b",
                             $time, pending_verdicts[0], verdict_if.is_num);
                    errors++;
                end
                void'(pending_verdicts.pop_front());
            end
        end
    end

    // run limit
    initial
    begin
        #3000000;
        $display("status: fail");
        $finish;
    end

    // main sequence
    initial
    begin
        rst_n            = 1'b0;
        chars_if.valid   = 1'b0;
        chars_if.ch      = '0;
        chars_if.no_char = 1'b0;
        chars_if.last    = 1'b0;
        errors           = 0;
        accepted_items   = 0;
        send_idle_pct    = 0;
        recv_stall_pct   = 0;
        hold_cycles      = 0;
        parse_state      = GS_START;
        repeat (6)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (directed_rows[i])
            send_item(directed_rows[i].it, directed_rows[i].mode, directed_rows[i].verdict);
        stop_sending();
        drain_verdicts();

        // random strings under each idle pattern
        run_random_phase(0, 0, 150);
        run_random_phase(74, 0, 150);
        run_random_phase(0, 74, 150);
        run_random_phase(23, 23, 150);

        // long receiver hold-off while the sender keeps offering
        hold_cycles = HOLD_OFF_CYCLES;
        run_random_phase(0, 0, 150);

        repeat (10)
            @(posedge clk);
        if (pending_verdicts.size() != 0)
        begin
            $display("%0t: %0d verdicts never arrived", $time, pending_verdicts.size());
            errors++;
        end
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire

@@ sim.f @@
+incdir+design
design/nsv_pkg.sv
design/nsv_in_if.sv
design/nsv_out_if.sv
design/nsv_char_class.sv
design/nsv_in_stage.sv
design/nsv_phase_fsm.sv
design/numeric_string_validator_core.sv
tb/tb.sv
